// ===== src/tcpcv_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpcv_pkg
// Shared types and constants for the TCP checksum verifier.
// ----------------------------------------------------------------------------
package tcpcv_pkg;

  // Byte positions relative to the start of the IPv4 header
  localparam logic [16:0] IHL_OFS      = 17'd0;
  localparam logic [16:0] TOTLEN_HI    = 17'd2;
  localparam logic [16:0] TOTLEN_LO    = 17'd3;
  localparam logic [16:0] ADDR_FIRST   = 17'd12;
  localparam logic [16:0] ADDR_LAST    = 17'd19;

  // Offset of the checksum field inside the TCP header
  localparam logic [16:0] CHK_OFS      = 17'd16;

  localparam logic [3:0]  IHL_MIN      = 4'd5;
  localparam logic [5:0]  HDR_MIN      = 6'd20;
  localparam logic [15:0] POS_MAX      = 16'hffff;
  localparam logic [15:0] PROTO_TCP    = 16'h0006;

  // Depth of the queue between front and back
  localparam int unsigned Q_DEPTH      = 2;

  // Role of one byte in the sum
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ADD_HI,   // address byte, upper half of a word
    KIND_ADD_LO,   // address byte, lower half of a word
    KIND_SEG_HI,   // segment byte at even offset, held
    KIND_SEG_LO    // segment byte at odd offset, completes a word
  } tcpcv_kind_e;

  // Classified byte passed from front to back
  typedef struct packed {
    tcpcv_kind_e  kind;
    logic [7:0]   val;
    logic         last;
    logic [15:0]  found;
    logic         trunc;
    logic [15:0]  seg_len;
  } tcpcv_item_t;

endpackage

// ===== src/tcpcv_in_if.sv =====
// ----------------------------------------------------------------------------
// tcpcv_in_if
// Byte stream channel: one frame byte per transaction.
// ----------------------------------------------------------------------------
interface tcpcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/tcpcv_out_if.sv =====
// ----------------------------------------------------------------------------
// tcpcv_out_if
// Result channel: one checksum verdict per frame.
// ----------------------------------------------------------------------------
interface tcpcv_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] computed_checksum;
  logic [15:0] received_checksum;
  logic        mismatch;
  logic        truncated;

  modport source (output valid, output computed_checksum, output received_checksum,
                  output mismatch, output truncated, input ready);
  modport sink   (input valid, input computed_checksum, input received_checksum,
                  input mismatch, input truncated, output ready);
endinterface

// ===== src/tcp_checksum_verifier_core.sv =====
// Result path: the last byte of a frame passes through a queue entry, the finish
//   stage and the result register before its result is valid; stalls add delay.
// Throughput: one byte per cycle while the queue is not full; the end-around add
//   in the back sets the rate, and a new frame may start right after the last byte.
// Reset: asynchronous, active low; clears all frame state, queue and result.
// ----------------------------------------------------------------------------
// tcp_checksum_verifier_core
// Verifies the TCP checksum of Ethernet/IPv4/TCP frames streamed bytewise.
// ----------------------------------------------------------------------------
module tcp_checksum_verifier_core #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcpcv_in_if.sink    byte_i,
  tcpcv_out_if.source result_o
);

  tcpcv_pkg::tcpcv_item_t f_item;
  tcpcv_pkg::tcpcv_item_t q_item;
  logic                   f_push;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;

  assign byte_i.ready = !q_full;

  // Front: position tracking and byte classification
  tcpcv_front #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (byte_i.valid),
    .data_byte_i (byte_i.data_byte),
    .last_byte_i (byte_i.last_byte),
    .ready_i     (byte_i.ready),
    .push_o      (f_push),
    .item_o      (f_item)
  );

  // Decoupling queue
  tcpcv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  // Back: accumulation and frame finish
  tcpcv_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_item_i            (q_item),
    .q_pop_o             (q_pop),
    .res_valid_o         (result_o.valid),
    .res_ready_i         (result_o.ready),
    .computed_checksum_o (result_o.computed_checksum),
    .received_checksum_o (result_o.received_checksum),
    .mismatch_o          (result_o.mismatch),
    .truncated_o         (result_o.truncated)
  );

endmodule

// ===== src/tcpcv_front.sv =====
// ----------------------------------------------------------------------------
// tcpcv_front
// Tracks the byte position, captures IPv4 header fields and the received
// checksum, and tags each byte with its role in the sum.
// ----------------------------------------------------------------------------
module tcpcv_front #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic                  ready_i,
  output logic                  push_o,
  output tcpcv_pkg::tcpcv_item_t item_o
);

  localparam logic [16:0] Base = 17'(LINK_HEADER_BYTES);

  logic [15:0] pos_q, pos_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] tot_q, tot_d;
  logic [15:0] found_q, found_d;

  logic        take;
  logic        acc;
  logic [16:0] p17;
  logic [16:0] n17;
  logic [5:0]  hb;
  logic [16:0] seg_start;
  logic [16:0] seg_end;
  logic        seg_short;
  logic        in_seg;
  logic        in_addr;
  logic        chk_byte;
  logic [15:0] pos_n;

  assign acc  = valid_i && ready_i;
  assign take = pos_q != tcpcv_pkg::POS_MAX;
  assign p17  = {1'b0, pos_q};

  // Header field capture
  always_comb begin
    ihl_d = ihl_q;
    tot_d = tot_q;
    if (take && p17 == Base + tcpcv_pkg::IHL_OFS) begin
      ihl_d = data_byte_i[3:0];
    end
    if (take && p17 == Base + tcpcv_pkg::TOTLEN_HI) begin
      tot_d = {data_byte_i, tot_q[7:0]};
    end
    if (take && p17 == Base + tcpcv_pkg::TOTLEN_LO) begin
      tot_d = {tot_q[15:8], data_byte_i};
    end
  end

  // Segment bounds
  assign hb        = (ihl_d < tcpcv_pkg::IHL_MIN) ? tcpcv_pkg::HDR_MIN : {ihl_d, 2'b00};
  assign seg_start = Base + 17'(hb);
  assign seg_short = tot_d < 16'(hb);
  assign seg_end   = seg_short ? seg_start : Base + {1'b0, tot_d};

  // Received checksum capture
  always_comb begin
    found_d = found_q;
    if (take && p17 == seg_start + tcpcv_pkg::CHK_OFS) begin
      found_d = {data_byte_i, found_q[7:0]};
    end
    if (take && p17 == seg_start + tcpcv_pkg::CHK_OFS + 17'd1) begin
      found_d = {found_q[15:8], data_byte_i};
    end
  end

  // Byte classification
  assign in_addr  = take && p17 >= Base + tcpcv_pkg::ADDR_FIRST
                         && p17 <= Base + tcpcv_pkg::ADDR_LAST;
  assign in_seg   = take && p17 >= seg_start && p17 < seg_end;
  assign chk_byte = p17 == seg_start + tcpcv_pkg::CHK_OFS
                 || p17 == seg_start + tcpcv_pkg::CHK_OFS + 17'd1;

  assign pos_n = take ? pos_q + 16'd1 : pos_q;
  assign n17   = {1'b0, pos_n};

  always_comb begin
    item_o.kind = tcpcv_pkg::KIND_NONE;
    if (in_addr) begin
      item_o.kind = (p17[0] == Base[0]) ? tcpcv_pkg::KIND_ADD_HI : tcpcv_pkg::KIND_ADD_LO;
    end else if (in_seg) begin
      item_o.kind = (p17[0] == seg_start[0]) ? tcpcv_pkg::KIND_SEG_HI
                                             : tcpcv_pkg::KIND_SEG_LO;
    end
    item_o.val     = (in_seg && chk_byte) ? 8'h00 : data_byte_i;
    item_o.last    = last_byte_i;
    item_o.found   = found_d;
    item_o.trunc   = n17 < seg_end;
    item_o.seg_len = seg_short ? 16'h0000 : tot_d - 16'(hb);
  end

  assign push_o = acc;

  // Next state: everything clears after the last byte of a frame
  always_comb begin
    pos_d = pos_q;
    if (acc) begin
      pos_d = last_byte_i ? 16'h0000 : pos_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ihl_q   <= '0;
      tot_q   <= '0;
      found_q <= '0;
    end else if (acc) begin
      pos_q <= pos_d;
      if (last_byte_i) begin
        ihl_q   <= '0;
        tot_q   <= '0;
        found_q <= '0;
      end else begin
        ihl_q   <= ihl_d;
        tot_q   <= tot_d;
        found_q <= found_d;
      end
    end
  end

`ifndef SYNTHESIS
  // A frame end restarts position tracking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_byte_i |=> pos_q == 16'h0000 && ihl_q == 4'd0)
    else $error("front state not cleared after frame end");
`endif

endmodule

// ===== src/tcpcv_queue.sv =====
// ----------------------------------------------------------------------------
// tcpcv_queue
// Small FIFO of classified bytes between the front and back.
// ----------------------------------------------------------------------------
module tcpcv_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tcpcv_pkg::tcpcv_item_t item_i,
  output logic                   full_o,
  output logic                   valid_o,
  output tcpcv_pkg::tcpcv_item_t item_o,
  input  logic                   pop_i
);

  localparam int unsigned Depth = tcpcv_pkg::Q_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tcpcv_pkg::tcpcv_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");
`endif

endmodule

// ===== src/tcpcv_back.sv =====
// ----------------------------------------------------------------------------
// tcpcv_back
// Accumulates the ones' complement sum, then finishes each frame with the
// pad byte, protocol and TCP length and drives the result register.
// ----------------------------------------------------------------------------
module tcpcv_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  tcpcv_pkg::tcpcv_item_t q_item_i,
  output logic                   q_pop_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [15:0]            computed_checksum_o,
  output logic [15:0]            received_checksum_o,
  output logic                   mismatch_o,
  output logic                   truncated_o
);

  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic        pend_vld_q, pend_vld_d;

  logic        fin_valid_q;
  logic [15:0] fin_sum_q;
  logic [7:0]  fin_pad_q;
  logic [15:0] fin_len_q;
  logic [15:0] fin_found_q;
  logic        fin_trunc_q;

  logic        out_valid_q;
  logic [15:0] out_comp_q;
  logic [15:0] out_found_q;
  logic        out_mis_q;
  logic        out_trunc_q;

  logic        out_free;
  logic        fin_free;
  logic        pop;
  logic [15:0] word;
  logic [16:0] add_t;
  logic [17:0] sum4;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] comp;

  assign out_free = !out_valid_q || res_ready_i;
  assign fin_free = !fin_valid_q || out_free;
  assign pop      = q_valid_i && (!q_item_i.last || fin_free);
  assign q_pop_o  = pop;

  // Word contributed by this byte
  always_comb begin
    word       = 16'h0000;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    unique case (q_item_i.kind)
      tcpcv_pkg::KIND_ADD_HI: word = {q_item_i.val, 8'h00};
      tcpcv_pkg::KIND_ADD_LO: word = {8'h00, q_item_i.val};
      tcpcv_pkg::KIND_SEG_HI: begin
        pend_d     = q_item_i.val;
        pend_vld_d = 1'b1;
      end
      tcpcv_pkg::KIND_SEG_LO: begin
        word       = {pend_q, q_item_i.val};
        pend_vld_d = 1'b0;
      end
      default: word = 16'h0000;
    endcase
  end

  // End-around carry add into the running sum
  assign add_t = {1'b0, sum_q} + {1'b0, word};
  assign sum_d = add_t[15:0] + 16'(add_t[16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
    end else if (pop) begin
      if (q_item_i.last) begin
        sum_q      <= '0;
        pend_q     <= '0;
        pend_vld_q <= 1'b0;
      end else begin
        sum_q      <= sum_d;
        pend_q     <= pend_d;
        pend_vld_q <= pend_vld_d;
      end
    end
  end

  // Frame finish stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (fin_free) begin
      fin_valid_q <= pop && q_item_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_free && pop && q_item_i.last) begin
      fin_sum_q   <= sum_d;
      fin_pad_q   <= pend_vld_d ? pend_d : 8'h00;
      fin_len_q   <= q_item_i.seg_len;
      fin_found_q <= q_item_i.found;
      fin_trunc_q <= q_item_i.trunc;
    end
  end

  // Pseudo-header tail, pad byte and final fold
  assign sum4  = {2'b00, fin_sum_q} + {2'b00, fin_pad_q, 8'h00}
               + {2'b00, fin_len_q} + {2'b00, tcpcv_pkg::PROTO_TCP};
  assign fold1 = {1'b0, sum4[15:0]} + 17'(sum4[17:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign comp  = ~fold2;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fin_valid_q) begin
      out_comp_q  <= comp;
      out_found_q <= fin_found_q;
      out_mis_q   <= comp != fin_found_q;
      out_trunc_q <= fin_trunc_q;
    end
  end

  assign res_valid_o         = out_valid_q;
  assign computed_checksum_o = out_comp_q;
  assign received_checksum_o = out_found_q;
  assign mismatch_o          = out_mis_q;
  assign truncated_o         = out_trunc_q;

`ifndef SYNTHESIS
  // A finished frame waits while the result register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && !out_free |=> fin_valid_q)
    else $error("finished frame dropped under stall");
  // Sum and pending byte restart after each frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && q_item_i.last |=> sum_q == 16'h0000 && !pend_vld_q)
    else $error("accumulator not cleared after frame end");
`endif

endmodule

// ===== verif/tb_tcp_checksum_verifier_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tcp_checksum_verifier_core
// Streams Ethernet/IPv4/TCP frames bytewise into the checksum verifier and
// scores every verdict against a cycle-free predictor. Frames are mostly
// well formed with random content, mixed with truncated, short-header,
// short-length and noise frames, under changing handshake pressure.
// ----------------------------------------------------------------------------
module tb_tcp_checksum_verifier_core;

  localparam int unsigned LINK_HDR       = 14;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TARGET_BYTES   = 1650;
  localparam int unsigned TARGET_FRAMES  = 20;

  // Handshake pressure applied while an item is in flight
  typedef enum int {
    MODE_STEADY,
    MODE_SEND_GAPS,
    MODE_RECV_STALL,
    MODE_BOTH
  } flow_mode_e;

  // Background content of a generated frame
  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    flow_mode_e mode;
    bit         drain;  // wait for all verdicts before offering
    bit         hold;   // kick off a long receiver hold-off
  } byte_item_t;

  typedef struct packed {
    logic [15:0] computed;
    logic [15:0] received;
    logic        mismatch;
    logic        truncated;
  } verdict_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [3:0]  ihl;
    logic [15:0] tot_len;
    logic [31:0] sum;
    logic [7:0]  held;
    logic [15:0] chk;
  } sum_state_t;

  logic clk_i;
  logic rst_ni;

  tcpcv_in_if  bi ();
  tcpcv_out_if ro ();

  tcp_checksum_verifier_core #(
    .LINK_HEADER_BYTES(LINK_HDR)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (bi),
    .result_o(ro)
  );

  byte_item_t  pend_q[$];
  verdict_t    verdict_q[$];
  logic [7:0]  frame_buf[$];
  sum_state_t  frame_st;
  flow_mode_e  cur_mode;
  int unsigned hold_tok;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned err_cnt;
  int unsigned frames_made;
  int unsigned bytes_made;
  int unsigned verdict_cnt;
  int unsigned mism_cnt;
  int unsigned trunc_cnt;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // End-around add, folded back to 16 bits
  function automatic logic [31:0] sum_fold(logic [31:0] acc, logic [31:0] add);
    logic [31:0] t;
    t = acc + add;
    t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
    t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
    return t;
  endfunction

  // IPv4 header size in bytes, short IHL taken as the minimum
  function automatic int unsigned hdr_bytes(logic [3:0] ihl);
    return (ihl < tcpcv_pkg::IHL_MIN) ? int'(tcpcv_pkg::HDR_MIN) : int'(ihl) * 4;
  endfunction

  // First byte position past the TCP segment
  function automatic int unsigned seg_stop(sum_state_t st, int unsigned start);
    if (st.tot_len < hdr_bytes(st.ihl)) return start;
    return LINK_HDR + st.tot_len;
  endfunction

  // Advance the frame state by one byte; returns 1 with a verdict on the last
  function automatic bit tcp_sum_step(inout sum_state_t st, input logic [7:0] b,
                                      input logic last, output verdict_t v);
    int unsigned p, start, stop, off, n, got;
    logic [31:0] s;
    logic [7:0]  w;
    logic [15:0] cs;
    p = st.pos;
    v = '0;
    if (p < tcpcv_pkg::POS_MAX) begin
      if (p == LINK_HDR + tcpcv_pkg::IHL_OFS) st.ihl = b[3:0];
      if (p == LINK_HDR + tcpcv_pkg::TOTLEN_HI) st.tot_len[15:8] = b;
      if (p == LINK_HDR + tcpcv_pkg::TOTLEN_LO) st.tot_len[7:0] = b;
      // source and destination addresses
      if (p >= LINK_HDR + tcpcv_pkg::ADDR_FIRST && p <= LINK_HDR + tcpcv_pkg::ADDR_LAST) begin
        st.sum = sum_fold(st.sum, ((p - LINK_HDR) & 1) ? {24'h0, b} : {16'h0, b, 8'h0});
      end
      start = LINK_HDR + hdr_bytes(st.ihl);
      stop  = seg_stop(st, start);
      // checksum field captured wherever it falls
      if (p == start + tcpcv_pkg::CHK_OFS) st.chk[15:8] = b;
      if (p == start + tcpcv_pkg::CHK_OFS + 1) st.chk[7:0] = b;
      if (p >= start && p < stop) begin
        off = p - start;
        w = (off == tcpcv_pkg::CHK_OFS || off == tcpcv_pkg::CHK_OFS + 1) ? 8'h00 : b;
        if (!off[0]) st.held = w;
        else st.sum = sum_fold(st.sum, {16'h0, st.held, w});
      end
      st.pos = p + 1;
    end
    if (!last) return 1'b0;

    // close the frame: odd pad, protocol, TCP length
    n     = st.pos;
    start = LINK_HDR + hdr_bytes(st.ihl);
    stop  = seg_stop(st, start);
    got   = 0;
    s     = st.sum;
    if (n > start) got = ((n < stop) ? n : stop) - start;
    if (got[0]) s = sum_fold(s, {16'h0, st.held, 8'h0});
    s  = sum_fold(s, {16'h0, tcpcv_pkg::PROTO_TCP});
    s  = sum_fold(s, (stop - start) & 32'hffff);
    cs = ~s[15:0];
    v.computed  = cs;
    v.received  = st.chk;
    v.mismatch  = (cs != st.chk);
    v.truncated = (n < stop);
    st = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Frame generation
  // --------------------------------------------------------------------------

  // Build a frame in frame_buf; tot_len < 0 means a consistent total length
  task automatic make_frame(input int ihl, input int seg_len, input int tot_len,
                            input int pad, input bit fix_chk, input fill_e fill);
    int unsigned hb, start, n, i, cpos;
    logic [15:0] tl;
    logic [7:0]  tmp;
    logic [3:0]  ihl4;
    sum_state_t  st;
    verdict_t    v;
    bit          got;
    ihl4  = ihl[3:0];
    hb    = hdr_bytes(ihl4);
    start = LINK_HDR + hb;
    n     = start + seg_len + pad;
    frame_buf.delete();
    for (i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: frame_buf.push_back(8'h00);
        FILL_ONES: frame_buf.push_back(8'hff);
        default:   frame_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    tmp = frame_buf[LINK_HDR + tcpcv_pkg::IHL_OFS];
    frame_buf[LINK_HDR + tcpcv_pkg::IHL_OFS] = {tmp[7:4], ihl4};
    tl = (tot_len < 0) ? 16'(hb + seg_len) : 16'(tot_len);
    frame_buf[LINK_HDR + tcpcv_pkg::TOTLEN_HI] = tl[15:8];
    frame_buf[LINK_HDR + tcpcv_pkg::TOTLEN_LO] = tl[7:0];
    // the field itself never enters the sum, so a dry run gives its value
    if (fix_chk) begin
      st = '0;
      for (i = 0; i < n; i++) got = tcp_sum_step(st, frame_buf[i], i == n - 1, v);
      cpos = start + tcpcv_pkg::CHK_OFS;
      if (cpos + 1 < n) begin
        frame_buf[cpos]     = v.computed[15:8];
        frame_buf[cpos + 1] = v.computed[7:0];
      end
    end
  endtask

  task automatic cut_frame(input int unsigned keep);
    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
  endtask

  task automatic make_noise(input int unsigned len);
    int unsigned i;
    frame_buf.delete();
    for (i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Queue frame_buf as one frame of byte transactions
  task automatic push_frame(input flow_mode_e mode, input bit drain, input bit hold);
    byte_item_t  it;
    int unsigned i;
    for (i = 0; i < frame_buf.size(); i++) begin
      it.data  = frame_buf[i];
      it.last  = (i == frame_buf.size() - 1);
      it.mode  = mode;
      it.drain = drain && (i == 0);
      it.hold  = hold && (i == 0);
      pend_q.push_back(it);
    end
    frames_made++;
    bytes_made += frame_buf.size();
  endtask

  // One random frame, weighted towards well-formed traffic
  task automatic random_frame(input flow_mode_e mode, input bit drain);
    int unsigned r, ihl, seg, pad;
    r   = $urandom_range(0, 99);
    ihl = $urandom_range(5, 15);
    seg = ($urandom_range(0, 9) < 7) ? $urandom_range(20, 80) : $urandom_range(0, 40);
    pad = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : 0;
    if (r < 60) begin
      make_frame(ihl, seg, -1, pad, $urandom_range(0, 1), FILL_RANDOM);
    end else if (r < 70) begin
      make_frame(ihl, seg, -1, pad, 1'b0, FILL_RANDOM);
      cut_frame($urandom_range(1, frame_buf.size() - 1));
    end else if (r < 78) begin
      make_frame($urandom_range(0, 4), $urandom_range(20, 40), -1, pad,
                 $urandom_range(0, 1), FILL_RANDOM);
    end else if (r < 85) begin
      make_frame(ihl, $urandom_range(10, 40), $urandom_range(0, ihl * 4 - 1), pad,
                 1'b0, FILL_RANDOM);
    end else if (r < 92) begin
      make_frame(ihl, seg, $urandom_range(0, 65535), pad, 1'b0, FILL_RANDOM);
    end else begin
      make_noise($urandom_range(1, 60));
    end
    push_frame(mode, drain, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Byte driver: presents the head of pend_q, predicts on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_drv
    byte_item_t it;
    verdict_t   v;
    bit         fire, nxt_valid;
    if (!rst_ni) begin
      bi.valid     <= 1'b0;
      bi.data_byte <= 8'h00;
      bi.last_byte <= 1'b0;
    end else begin
      fire = bi.valid && bi.ready;
      if (fire) begin
        it = pend_q.pop_front();
        if (tcp_sum_step(frame_st, it.data, it.last, v)) verdict_q.push_back(v);
      end
      // an offered transaction stays until taken
      if (!(bi.valid && !fire)) begin
        nxt_valid = 1'b0;
        if (pend_q.size() != 0) begin
          if (pend_q[0].drain && verdict_q.size() == 0) pend_q[0].drain = 1'b0;
          if (!pend_q[0].drain) begin
            if (pend_q[0].hold) begin
              hold_tok <= hold_tok + 1;
              pend_q[0].hold = 1'b0;
            end
            cur_mode <= pend_q[0].mode;
            case (pend_q[0].mode)
              MODE_SEND_GAPS: nxt_valid = ($urandom_range(0, 99) >= 76);
              MODE_BOTH:      nxt_valid = ($urandom_range(0, 99) >= 32);
              default:        nxt_valid = 1'b1;
            endcase
          end
        end
        bi.valid <= nxt_valid;
        if (nxt_valid) begin
          bi.data_byte <= pend_q[0].data;
          bi.last_byte <= pend_q[0].last;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Verdict monitor: scores results, drives ready with stalls and hold-offs
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : verdict_mon
    verdict_t exp_v;
    bit       nxt_ready;
    if (!rst_ni) begin
      ro.ready <= 1'b0;
    end else begin
      if (ro.valid && ro.ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict arrived with none expected: computed %h received %h",
                 ro.computed_checksum, ro.received_checksum);
          err_cnt++;
        end else begin
          exp_v = verdict_q.pop_front();
          verdict_cnt++;
          if (exp_v.mismatch) mism_cnt++;
          if (exp_v.truncated) trunc_cnt++;
          if (ro.computed_checksum !== exp_v.computed) begin
            $error("computed_checksum: expected %h, actual %h",
                   exp_v.computed, ro.computed_checksum);
            err_cnt++;
          end
          if (ro.received_checksum !== exp_v.received) begin
            $error("received_checksum: expected %h, actual %h",
                   exp_v.received, ro.received_checksum);
            err_cnt++;
          end
          if (ro.mismatch !== exp_v.mismatch) begin
            $error("mismatch: expected %b, actual %b", exp_v.mismatch, ro.mismatch);
            err_cnt++;
          end
          if (ro.truncated !== exp_v.truncated) begin
            $error("truncated: expected %b, actual %b", exp_v.truncated, ro.truncated);
            err_cnt++;
          end
        end
      end
      // long hold-off takes priority over random stalls
      if (hold_left != 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (hold_tok != hold_seen) begin
        hold_seen = hold_tok;
        hold_left = HOLD_CYCLES;
        nxt_ready = 1'b0;
      end else begin
        case (cur_mode)
          MODE_RECV_STALL: nxt_ready = ($urandom_range(0, 99) >= 76);
          MODE_BOTH:       nxt_ready = ($urandom_range(0, 99) >= 32);
          default:         nxt_ready = 1'b1;
        endcase
      end
      ro.ready <= nxt_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog on cycles with no transaction on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((bi.valid && bi.ready) || (ro.valid && ro.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned k;
    flow_mode_e  mode;
    bi.valid     = 1'b0;
    bi.data_byte = 8'h00;
    bi.last_byte = 1'b0;
    ro.ready     = 1'b0;
    rst_ni       = 1'b0;
    frame_st     = '0;
    cur_mode     = MODE_STEADY;
    hold_tok     = 0;
    hold_seen    = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    err_cnt      = 0;
    frames_made  = 0;
    bytes_made   = 0;
    verdict_cnt  = 0;
    mism_cnt     = 0;
    trunc_cnt    = 0;

    // directed: one-byte frames at both byte extremes
    frame_buf = {8'h00};
    push_frame(MODE_STEADY, 1'b0, 1'b0);
    frame_buf = {8'hff};
    push_frame(MODE_STEADY, 1'b0, 1'b0);
    // minimal frame of zeros with a correct checksum
    make_frame(5, 20, -1, 0, 1'b1, FILL_ZERO);
    push_frame(MODE_STEADY, 1'b0, 1'b0);
    // largest header, odd segment, all ones
    make_frame(15, 21, -1, 0, 1'b1, FILL_ONES);
    push_frame(MODE_STEADY, 1'b0, 1'b0);
    // IHL below the minimum
    make_frame(0, 24, -1, 2, 1'b0, FILL_RANDOM);
    push_frame(MODE_STEADY, 1'b0, 1'b0);
    // total length shorter than the header
    make_frame(6, 30, 10, 0, 1'b0, FILL_RANDOM);
    push_frame(MODE_STEADY, 1'b0, 1'b0);
    // checksum field past the segment end, in the padding
    make_frame(5, 10, -1, 12, 1'b1, FILL_RANDOM);
    push_frame(MODE_STEADY, 1'b0, 1'b0);
    // truncated after an odd number of segment bytes
    make_frame(5, 40, -1, 0, 1'b0, FILL_RANDOM);
    cut_frame(LINK_HDR + 20 + 7);
    push_frame(MODE_STEADY, 1'b0, 1'b0);
    // truncated right after the IHL byte, maximal total length
    make_frame(15, 40, 16'hffff, 0, 1'b0, FILL_ONES);
    cut_frame(LINK_HDR + 1);
    push_frame(MODE_STEADY, 1'b0, 1'b0);
    // empty segment
    make_frame(5, 0, -1, 0, 1'b1, FILL_RANDOM);
    push_frame(MODE_STEADY, 1'b1, 1'b0);

    // random traffic, handshake mix rotating every two frames
    k = 0;
    while (bytes_made < TARGET_BYTES || frames_made < TARGET_FRAMES) begin
      mode = flow_mode_e'((k / 2) % 4);
      random_frame(mode, (k % 12) == 11);
      // burst of tiny frames against a held-off receiver
      if (k == 8) begin
        make_noise($urandom_range(1, 3));
        push_frame(MODE_STEADY, 1'b1, 1'b1);
        repeat (30) begin
          make_noise($urandom_range(1, 3));
          push_frame(MODE_STEADY, 1'b0, 1'b0);
        end
      end
      k++;
    end

    // one-byte frame after a full drain
    frame_buf = {8'h5a};
    push_frame(MODE_BOTH, 1'b1, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || bi.valid) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d frames (%0d bytes) across four handshake mixes, a held-off burst",
             frames_made, bytes_made);
    $display("and drained pauses; %0d verdicts scored, %0d mismatching, %0d truncated.",
             verdict_cnt, mism_cnt, trunc_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
